// ===== design/assert_macros.svh =====
// Assertion helper macros used by the circle center estimator solver RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/tofcc_pkg.sv =====
// Shared types and constants of the circle center estimator.
// No dependencies.
package tofcc_pkg;

  localparam int MAX_SENSORS = 32;
  localparam int IDX_W       = $clog2(MAX_SENSORS + 1);

  localparam int X_W     = 11;
  localparam int Y_W     = 16;
  localparam int PITCH_W = 8;
  localparam int COORD_W = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXD  = 1'd1;
  localparam logic [PITCH_W-1:0]   PITCH_RST = 8'd50;
  localparam logic [X_W-1:0]       MAXD_RST  = 11'd1096;

  // Solver datapath widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = 52;
  localparam int A_W     = 13;
  localparam int B_W     = 18;
  localparam int C_W     = 34;
  localparam int NUM_W   = 53;
  localparam int DET_W   = 32;
  localparam int DVD_W   = 55;
  localparam int DVS_W   = 33;
  localparam int Q_W     = 17;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [X_W-1:0] distance;
    logic           last_sensor;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic               found;
  } out_t;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [X_W-1:0]     max_dist;
  } cfg_t;

  // Fewer than three hits, exactly three, more than three
  typedef enum logic [1:0] {CLS_NONE, CLS_ONE, CLS_TWO} cls_e;

  typedef struct packed {
    cls_e         cls;
    point_t [5:0] pts;  // first three, then newest three newest first
  } job_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quo;  // clamped quotient
  } div_rsp_t;

endpackage

// ===== design/tofcc_front.sv =====
// Front end: takes readings, builds hit points, keeps first and recent hits.
// Pushes one solve job per frame. Depends on tofcc_pkg.
module tofcc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tofcc_pkg::in_t    in_data_i,
  input  tofcc_pkg::cfg_t   cfg_i,
  input  logic              job_full_i,
  output logic              job_push_o,
  output tofcc_pkg::job_t   job_o
);

  logic [tofcc_pkg::IDX_W-1:0] idx_q, idx_d, hcnt_q, hcnt_d, hcnt_n;
  logic [1:0] wp_q, wp_d, wp_n, nw0, nw1, nw2;
  tofcc_pkg::point_t first_q [3];
  tofcc_pkg::point_t first_d [3];
  tofcc_pkg::point_t ring_q [3];
  tofcc_pkg::point_t ring_d [3];
  tofcc_pkg::point_t pt;
  logic [tofcc_pkg::IDX_W+tofcc_pkg::PITCH_W-1:0] yprod;
  logic acc, in_rng, hit;

  function automatic logic [1:0] dec3(input logic [1:0] v);
    dec3 = (v == 2'd0) ? 2'd2 : v - 2'd1;
  endfunction

  assign in_ready_o = !job_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign in_rng     = idx_q < tofcc_pkg::IDX_W'(tofcc_pkg::MAX_SENSORS);
  assign hit        = acc && in_rng && (in_data_i.distance < cfg_i.max_dist);
  assign yprod      = idx_q * cfg_i.pitch;
  assign pt.x       = in_data_i.distance;
  assign pt.y       = tofcc_pkg::Y_W'(yprod);

  always_comb begin
    first_d = first_q;
    ring_d  = ring_q;
    wp_n    = wp_q;
    hcnt_n  = hcnt_q;
    if (hit) begin
      if (hcnt_q < tofcc_pkg::IDX_W'(3)) begin
        first_d[hcnt_q[1:0]] = pt;
      end
      ring_d[wp_q] = pt;
      wp_n   = (wp_q == 2'd2) ? 2'd0 : wp_q + 2'd1;
      hcnt_n = hcnt_q + tofcc_pkg::IDX_W'(1);
    end
    idx_d  = (acc && in_rng) ? idx_q + tofcc_pkg::IDX_W'(1) : idx_q;
    hcnt_d = hcnt_n;
    wp_d   = wp_n;
    if (acc && in_data_i.last_sensor) begin
      idx_d  = '0;
      hcnt_d = '0;
      wp_d   = 2'd0;
    end
  end

  // Newest first from the updated ring
  assign nw0 = dec3(wp_n);
  assign nw1 = dec3(nw0);
  assign nw2 = dec3(nw1);

  always_comb begin
    job_o.pts[0] = first_d[0];
    job_o.pts[1] = first_d[1];
    job_o.pts[2] = first_d[2];
    job_o.pts[3] = ring_d[nw0];
    job_o.pts[4] = ring_d[nw1];
    job_o.pts[5] = ring_d[nw2];
    if (hcnt_n < tofcc_pkg::IDX_W'(3)) begin
      job_o.cls = tofcc_pkg::CLS_NONE;
    end else if (hcnt_n == tofcc_pkg::IDX_W'(3)) begin
      job_o.cls = tofcc_pkg::CLS_ONE;
    end else begin
      job_o.cls = tofcc_pkg::CLS_TWO;
    end
  end

  assign job_push_o = acc && in_data_i.last_sensor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hcnt_q <= '0;
      wp_q   <= 2'd0;
    end else begin
      idx_q  <= idx_d;
      hcnt_q <= hcnt_d;
      wp_q   <= wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    ring_q  <= ring_d;
  end

endmodule

// ===== design/tofcc_fifo.sv =====
// Two-entry job queue between front end and solver.
// Depends on tofcc_pkg.
module tofcc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tofcc_pkg::job_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tofcc_pkg::job_t pop_data_o
);

  tofcc_pkg::job_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== design/tofcc_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient clamped.
// Depends on tofcc_pkg.
module tofcc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tofcc_pkg::div_req_t req_i,
  output tofcc_pkg::div_rsp_t rsp_o
);

  logic busy_q, done_q;
  logic [tofcc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [tofcc_pkg::DVD_W-1:0] dvd_q, quo_q;
  logic [tofcc_pkg::DVS_W-1:0] dvs_q, rem_q, rem_d;
  logic [tofcc_pkg::DVS_W:0]   shf, trial;
  logic qbit;

  assign shf   = {rem_q, dvd_q[tofcc_pkg::DVD_W-1]};
  assign trial = shf - {1'b0, dvs_q};
  assign qbit  = !trial[tofcc_pkg::DVS_W];
  assign rem_d = qbit ? trial[tofcc_pkg::DVS_W-1:0] : shf[tofcc_pkg::DVS_W-1:0];

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = (|quo_q[tofcc_pkg::DVD_W-1:tofcc_pkg::Q_W]) ? '1
                                                                  : quo_q[tofcc_pkg::Q_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= tofcc_pkg::DIV_CNT_W'(tofcc_pkg::DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - tofcc_pkg::DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[tofcc_pkg::DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[tofcc_pkg::DVD_W-2:0], qbit};
    end
  end

endmodule

// ===== design/tofcc_back.sv =====
// Solver: circumcenter by Cramer's rule over a shared multiplier and divider,
// averaging, saturation and the output register. Depends on tofcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tofcc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  tofcc_pkg::job_t     job_i,
  output logic                job_pop_o,
  output tofcc_pkg::div_req_t div_req_o,
  input  tofcc_pkg::div_rsp_t div_rsp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tofcc_pkg::out_t     out_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIVX  = 3'd2;
  localparam logic [2:0] S_WAITX = 3'd3;
  localparam logic [2:0] S_DIVY  = 3'd4;
  localparam logic [2:0] S_WAITY = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [3:0] STP_COMB = 4'd6;
  localparam logic [3:0] STP_DIFF = 4'd13;

  logic [2:0] state_q, state_d;
  logic [3:0] stp_q, widx;
  logic       tri_q;
  tofcc_pkg::job_t job_q;
  tofcc_pkg::point_t p1, p2, p3;

  logic signed [tofcc_pkg::PROD_W-1:0] prd_q [12];
  logic signed [tofcc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tofcc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [tofcc_pkg::PROD_W-1:0]  prod;

  logic [tofcc_pkg::A_W-1:0] a1_q, a2_q, a1_d, a2_d;
  logic [tofcc_pkg::B_W-1:0] b1_q, b2_q, b1_d, b2_d;
  logic [tofcc_pkg::C_W-1:0] c1_q, c2_q;
  logic [tofcc_pkg::PROD_W-1:0] c1_w, c2_w;
  logic [tofcc_pkg::A_W-2:0] ta1, ta2;
  logic [tofcc_pkg::B_W-2:0] tb1, tb2;

  logic [tofcc_pkg::DET_W-1:0] det_w, dmag_q;
  logic [tofcc_pkg::NUM_W-1:0] nx_w, ny_w, nxm_q, nym_q;
  logic                        dzero_q;
  logic [tofcc_pkg::Q_W-1:0]   qx_q [2];
  logic [tofcc_pkg::Q_W-1:0]   qy_q [2];
  logic [tofcc_pkg::Q_W:0]     sx, sy;
  logic [tofcc_pkg::Q_W-1:0]   rx, ry;

  logic out_valid_q, out_wr;
  tofcc_pkg::out_t out_q, out_d;

  function automatic logic [tofcc_pkg::NUM_W-1:0] mag_n(input logic [tofcc_pkg::NUM_W-1:0] v);
    mag_n = v[tofcc_pkg::NUM_W-1] ? -v : v;
  endfunction

  function automatic logic [tofcc_pkg::COORD_W-1:0] sat(input logic [tofcc_pkg::Q_W-1:0] v);
    sat = v[tofcc_pkg::Q_W-1] ? '1 : v[tofcc_pkg::COORD_W-1:0];
  endfunction

  assign p1 = tri_q ? job_q.pts[3] : job_q.pts[0];
  assign p2 = tri_q ? job_q.pts[4] : job_q.pts[1];
  assign p3 = tri_q ? job_q.pts[5] : job_q.pts[2];

  // Multiplier operand select: squares first, then the Cramer products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (stp_q)
      4'd0: begin mul_a = $signed(tofcc_pkg::MUL_A_W'(p1.x)); mul_b = $signed(tofcc_pkg::MUL_B_W'(p1.x)); end
      4'd1: begin mul_a = $signed(tofcc_pkg::MUL_A_W'(p2.x)); mul_b = $signed(tofcc_pkg::MUL_B_W'(p2.x)); end
      4'd2: begin mul_a = $signed(tofcc_pkg::MUL_A_W'(p3.x)); mul_b = $signed(tofcc_pkg::MUL_B_W'(p3.x)); end
      4'd3: begin mul_a = $signed(tofcc_pkg::MUL_A_W'(p1.y)); mul_b = $signed(tofcc_pkg::MUL_B_W'(p1.y)); end
      4'd4: begin mul_a = $signed(tofcc_pkg::MUL_A_W'(p2.y)); mul_b = $signed(tofcc_pkg::MUL_B_W'(p2.y)); end
      4'd5: begin mul_a = $signed(tofcc_pkg::MUL_A_W'(p3.y)); mul_b = $signed(tofcc_pkg::MUL_B_W'(p3.y)); end
      4'd7: begin
        mul_a = tofcc_pkg::MUL_A_W'($signed(a1_q));
        mul_b = $signed(b2_q);
      end
      4'd8: begin
        mul_a = tofcc_pkg::MUL_A_W'($signed(a2_q));
        mul_b = $signed(b1_q);
      end
      4'd9:  begin mul_a = $signed(c1_q); mul_b = $signed(b2_q); end
      4'd10: begin mul_a = $signed(c2_q); mul_b = $signed(b1_q); end
      4'd11: begin mul_a = $signed(c2_q); mul_b = tofcc_pkg::MUL_B_W'($signed(a1_q)); end
      4'd12: begin mul_a = $signed(c1_q); mul_b = tofcc_pkg::MUL_B_W'($signed(a2_q)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign widx = (stp_q < STP_COMB) ? stp_q : stp_q - 4'd1;

  // a = -2(x2 - x1) = 2(x1 - x2), b likewise
  assign ta1  = {1'b0, p1.x} - {1'b0, p2.x};
  assign ta2  = {1'b0, p1.x} - {1'b0, p3.x};
  assign tb1  = {1'b0, p1.y} - {1'b0, p2.y};
  assign tb2  = {1'b0, p1.y} - {1'b0, p3.y};
  assign a1_d = {ta1, 1'b0};
  assign a2_d = {ta2, 1'b0};
  assign b1_d = {tb1, 1'b0};
  assign b2_d = {tb2, 1'b0};
  assign c1_w = prd_q[1] - prd_q[0] + prd_q[4] - prd_q[3];
  assign c2_w = prd_q[2] - prd_q[0] + prd_q[5] - prd_q[3];

  // det fits 32 bits, so wrapping arithmetic on the low part is exact
  assign det_w = prd_q[6][tofcc_pkg::DET_W-1:0] - prd_q[7][tofcc_pkg::DET_W-1:0];
  assign nx_w  = {prd_q[8][tofcc_pkg::PROD_W-1], prd_q[8]}
               - {prd_q[9][tofcc_pkg::PROD_W-1], prd_q[9]};
  assign ny_w  = {prd_q[10][tofcc_pkg::PROD_W-1], prd_q[10]}
               - {prd_q[11][tofcc_pkg::PROD_W-1], prd_q[11]};

  // Rounded quotient: (2n + d) / 2d
  always_comb begin
    div_req_o.start    = (state_q == S_DIVX) || (state_q == S_DIVY);
    div_req_o.divisor  = {dmag_q, 1'b0};
    div_req_o.dividend = tofcc_pkg::DVD_W'({(state_q == S_DIVY) ? nym_q : nxm_q, 1'b0})
                       + tofcc_pkg::DVD_W'(dmag_q);
  end

  // Quotients are clamped, so the average of clamped values saturates alike
  assign sx = {1'b0, qx_q[0]} + {1'b0, qx_q[1]};
  assign sy = {1'b0, qy_q[0]} + {1'b0, qy_q[1]};
  assign rx = (job_q.cls == tofcc_pkg::CLS_TWO) ? sx[tofcc_pkg::Q_W:1] : qx_q[0];
  assign ry = (job_q.cls == tofcc_pkg::CLS_TWO) ? sy[tofcc_pkg::Q_W:1] : qy_q[0];

  always_comb begin
    out_d.found    = job_q.cls != tofcc_pkg::CLS_NONE;
    out_d.center_x = out_d.found ? sat(rx) : '0;
    out_d.center_y = out_d.found ? sat(ry) : '0;
  end

  assign out_wr    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_i.cls == tofcc_pkg::CLS_NONE) ? S_OUT : S_MUL;
        end
      end
      S_MUL: begin
        if (stp_q == STP_DIFF) begin
          state_d = (det_w == '0) ? S_NEXT : S_DIVX;
        end
      end
      S_DIVX:  state_d = S_WAITX;
      S_WAITX: if (div_rsp_i.done) state_d = S_DIVY;
      S_DIVY:  state_d = S_WAITY;
      S_WAITY: if (div_rsp_i.done) state_d = S_NEXT;
      S_NEXT: begin
        state_d = (!tri_q && job_q.cls == tofcc_pkg::CLS_TWO) ? S_MUL : S_OUT;
      end
      S_OUT:   if (out_wr) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stp_q       <= 4'd0;
      tri_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        stp_q <= 4'd0;
        tri_q <= 1'b0;
      end else if (state_q == S_MUL && stp_q != STP_DIFF) begin
        stp_q <= stp_q + 4'd1;
      end else if (state_q == S_NEXT) begin
        stp_q <= 4'd0;
        tri_q <= 1'b1;
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (state_q == S_MUL) begin
      if (stp_q == STP_COMB) begin
        a1_q <= a1_d;
        a2_q <= a2_d;
        b1_q <= b1_d;
        b2_q <= b2_d;
        c1_q <= c1_w[tofcc_pkg::C_W-1:0];
        c2_q <= c2_w[tofcc_pkg::C_W-1:0];
      end else if (stp_q == STP_DIFF) begin
        dzero_q <= det_w == '0;
        dmag_q  <= det_w[tofcc_pkg::DET_W-1] ? -det_w : det_w;
        nxm_q   <= mag_n(nx_w);
        nym_q   <= mag_n(ny_w);
      end else begin
        prd_q[widx] <= prod;
      end
    end
    if (state_q == S_WAITX && div_rsp_i.done) begin
      qx_q[tri_q] <= div_rsp_i.quo;
    end
    if (state_q == S_WAITY && div_rsp_i.done) begin
      qy_q[tri_q] <= div_rsp_i.quo;
    end
    if (state_q == S_MUL && stp_q == STP_DIFF && det_w == '0) begin
      qx_q[tri_q] <= '0;
      qy_q[tri_q] <= '0;
    end
    if (out_wr) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_div_start_idle, div_req_o.start, !div_rsp_i.busy)
  `ASSERT_IMPL(a_div_nonzero, div_req_o.start, !dzero_q)
  `ASSERT_IMPL(a_notfound_zero, out_valid_q && !out_q.found,
               out_q.center_x == '0 && out_q.center_y == '0)
  `ASSERT_NEXT(a_pop_leaves_idle, job_pop_o, state_q != S_IDLE)

endmodule

// ===== design/tof_hits_circle_center_estimator_top.sv =====
// Channel       | dir | handshake               | payload
// in            | in  | in_valid_i / in_ready_o   | tofcc_pkg::in_t
// out           | out | out_valid_o / out_ready_i | tofcc_pkg::out_t
// cfg           | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Readings are taken one per cycle; input stalls only while the job queue is full.
// Solve per frame: each triple runs 14 solver steps, two divides on the shared
// divider and one switch step; a zero determinant skips both divides and gives zero
// quotients. Jobs are popped only in idle, and output stalls hold the solver.
// A frame with fewer than three hits is popped and goes straight to the output state.
// Reset clears counters and control and loads config defaults; no clearing pass.
//
// Top level; depends on tofcc_pkg, tofcc_front, tofcc_fifo, tofcc_div, tofcc_back.
module tof_hits_circle_center_estimator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tofcc_pkg::in_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tofcc_pkg::out_t                    out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tofcc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tofcc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tofcc_pkg::cfg_t     cfg_q;
  tofcc_pkg::job_t     push_job, pop_job;
  tofcc_pkg::div_req_t div_req;
  tofcc_pkg::div_rsp_t div_rsp;
  logic push, full, pop, jvalid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch    <= tofcc_pkg::PITCH_RST;
      cfg_q.max_dist <= tofcc_pkg::MAXD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tofcc_pkg::CFG_PITCH: cfg_q.pitch    <= cfg_data_i[tofcc_pkg::PITCH_W-1:0];
        tofcc_pkg::CFG_MAXD:  cfg_q.max_dist <= cfg_data_i[tofcc_pkg::X_W-1:0];
        default: ;
      endcase
    end
  end

  tofcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .job_full_i (full),
    .job_push_o (push),
    .job_o      (push_job)
  );

  tofcc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (jvalid),
    .pop_data_o  (pop_job)
  );

  tofcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tofcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (jvalid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
